// ===== rtl/square_matrix_multiply_unit_assert.svh =====
// ----------------------------------------------------------------------------
// square_matrix_multiply_unit_assert.svh
// assertion macros shared by the checker files of the matrix multiply unit
// ----------------------------------------------------------------------------
`ifndef SQUARE_MATRIX_MULTIPLY_UNIT_ASSERT_SVH
`define SQUARE_MATRIX_MULTIPLY_UNIT_ASSERT_SVH

// consequent must hold on the same edge as the antecedent
`define SMM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |-> (cons)) \
    else $error("smm port check failed");

// consequent must hold on the edge after the antecedent
`define SMM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("smm port check failed");

`endif

// ===== rtl/smm_pkg.sv =====
// ----------------------------------------------------------------------------
// smm_pkg
// field widths, input mode codes and controller/datapath bundles of the
// square matrix multiply unit
// ----------------------------------------------------------------------------
`default_nettype none

package smm_pkg;

  // fixed field widths of the channels and the size register
  localparam int MODE_W    = 2;
  localparam int ROW_W     = 4;
  localparam int COL_W     = 4;
  localparam int ELEM_IN_W = 16;
  localparam int SUM_W     = 36;
  localparam int CFG_W     = 5;

  // the col and k index fields in the bundles are six bits wide (indices up to 63)
  localparam int IDX_MAX_W = 6;

  // input beat modes
  localparam logic [MODE_W-1:0] MODE_WR_A    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_WR_B    = 2'd1;
  localparam logic [MODE_W-1:0] MODE_COMPUTE = 2'd2;

  // size register after reset
  localparam logic [CFG_W-1:0] SIZE_RESET = 5'd16;

  // controller to datapath
  typedef struct packed {
    logic                 wr_a;
    logic                 wr_b;
    logic                 rd_en;
    logic                 rd_first;
    logic                 rd_last;
    logic                 load_out;
    logic                 out_last;
    logic [ROW_W-1:0]     row;
    logic [IDX_MAX_W-1:0] col;
    logic [IDX_MAX_W-1:0] k;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic sum_ready;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/smm_in_if.sv =====
// ----------------------------------------------------------------------------
// smm_in_if
// input channel: element loads and row compute requests
// ----------------------------------------------------------------------------
`default_nettype none

interface smm_in_if import smm_pkg::*; ();

  logic                        valid;
  logic                        ready;
  logic [MODE_W-1:0]           mode;
  logic [ROW_W-1:0]            row_index;
  logic [COL_W-1:0]            col_index;
  logic signed [ELEM_IN_W-1:0] elem_value;

  modport source (
    output valid, mode, row_index, col_index, elem_value,
    input  ready
  );

  modport sink (
    input  valid, mode, row_index, col_index, elem_value,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/smm_out_if.sv =====
// ----------------------------------------------------------------------------
// smm_out_if
// result channel: one beat per element of a computed row
// ----------------------------------------------------------------------------
`default_nettype none

interface smm_out_if import smm_pkg::*; ();

  logic                    valid;
  logic                    ready;
  logic [ROW_W-1:0]        out_row;
  logic [COL_W-1:0]        out_col;
  logic signed [SUM_W-1:0] dot_sum;
  logic                    last_in_row;

  modport source (
    output valid, out_row, out_col, dot_sum, last_in_row,
    input  ready
  );

  modport sink (
    input  valid, out_row, out_col, dot_sum, last_in_row,
    output ready
  );

endinterface

`default_nettype wire

// ===== rtl/smm_ram.sv =====
// ----------------------------------------------------------------------------
// smm_ram
// generic single write port, single read port ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                                 clk,
  input  logic                                 we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                     wdata,
  input  logic                                 re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/smm_ctrl.sv =====
// ----------------------------------------------------------------------------
// smm_ctrl
// sequencer of the matrix multiply unit: holds the size register, accepts
// input beats and steps the column and term counters of a row compute
// ----------------------------------------------------------------------------
`default_nettype none

module smm_ctrl import smm_pkg::*; #(
  parameter int MAX_N = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [MODE_W-1:0] in_mode,
  input  logic [ROW_W-1:0]  in_row,
  input  status_t           status,
  output cmd_t              cmd
);

  localparam int IDX_W = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CNT_W = $clog2(MAX_N + 1);
  localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_MAC   = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_EMIT  = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CFG_W-1:0] size_r;
  logic [ROW_W-1:0] row_r, row_nxt;
  logic [CNT_W-1:0] n_r, n_nxt;
  logic [IDX_W-1:0] j_r, j_nxt;
  logic [IDX_W-1:0] k_r, k_nxt;
  logic [CNT_W-1:0] n_act;
  logic             accept;
  logic             k_last;
  logic             j_last;

  // size in use: zero counts as one, clamp to the store size
  always_comb begin
    if (size_r == '0) begin
      n_act = CNT_W'(1);
    end else if (CMP_W'(size_r) > CMP_W'(MAX_N)) begin
      n_act = CNT_W'(MAX_N);
    end else begin
      n_act = CNT_W'(size_r);
    end
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign k_last   = (CNT_W'(k_r) + CNT_W'(1)) == n_r;
  assign j_last   = (CNT_W'(j_r) + CNT_W'(1)) == n_r;

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    row_nxt      = row_r;
    n_nxt        = n_r;
    j_nxt        = j_r;
    k_nxt        = k_r;
    cmd          = '0;
    cmd.row      = row_r;
    cmd.col      = IDX_MAX_W'(j_r);
    cmd.k        = IDX_MAX_W'(k_r);
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_mode)
            MODE_WR_A: cmd.wr_a = 1'b1;
            MODE_WR_B: cmd.wr_b = 1'b1;
            MODE_COMPUTE: begin
              // a row outside the size in use gives no beats
              if (CMP_W'(in_row) < CMP_W'(n_act)) begin
                row_nxt   = in_row;
                n_nxt     = n_act;
                j_nxt     = '0;
                k_nxt     = '0;
                state_nxt = S_MAC;
              end
            end
            default: ;
          endcase
        end
      end
      S_MAC: begin
        cmd.rd_en    = 1'b1;
        cmd.rd_first = (k_r == '0);
        cmd.rd_last  = k_last;
        if (k_last) begin
          state_nxt = S_DRAIN;
        end else begin
          k_nxt = k_r + IDX_W'(1);
        end
      end
      S_DRAIN: begin
        if (status.sum_ready) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!status.out_busy) begin
          cmd.load_out = 1'b1;
          cmd.out_last = j_last;
          if (j_last) begin
            state_nxt = S_IDLE;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            k_nxt     = '0;
            state_nxt = S_MAC;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state and size register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= SIZE_RESET;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        size_r <= cfg_data;
      end
    end
  end

  // counters and latched row
  always_ff @(posedge clk) begin
    row_r <= row_nxt;
    n_r   <= n_nxt;
    j_r   <= j_nxt;
    k_r   <= k_nxt;
  end

endmodule

`default_nettype wire

// ===== rtl/smm_datapath.sv =====
// ----------------------------------------------------------------------------
// smm_datapath
// element stores, shared multiply-accumulate pipeline and result register
// ----------------------------------------------------------------------------
`default_nettype none

module smm_datapath import smm_pkg::*; #(
  parameter int MAX_N      = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  cmd_t                        cmd,
  output status_t                     status,
  input  logic [ROW_W-1:0]            in_row,
  input  logic [COL_W-1:0]            in_col,
  input  logic signed [ELEM_IN_W-1:0] in_elem,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [ROW_W-1:0]            out_row,
  output logic [COL_W-1:0]            out_col,
  output logic signed [SUM_W-1:0]     out_sum,
  output logic                        out_last
);

  localparam int IDX_W  = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int DEPTH  = MAX_N * MAX_N;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int LOAD_W = (ELEM_WIDTH < ELEM_IN_W) ? ELEM_WIDTH : ELEM_IN_W;
  localparam int PROD_W = 2 * ELEM_WIDTH;
  localparam int EXT_W  = (PROD_W > SUM_W) ? PROD_W : SUM_W;

  logic                     in_range;
  logic [ADDR_W-1:0]        wr_addr;
  logic [ELEM_WIDTH-1:0]    wr_elem;
  logic [IDX_W-1:0]         rd_k;
  logic [IDX_W-1:0]         rd_j;
  logic [ADDR_W-1:0]        rd_addr_a;
  logic [ADDR_W-1:0]        rd_addr_b;
  logic [ELEM_WIDTH-1:0]    a_rd;
  logic [ELEM_WIDTH-1:0]    b_rd;
  logic                     v1_r, v2_r;
  logic                     first1_r, first2_r;
  logic                     last1_r, last2_r;
  logic signed [PROD_W-1:0] prod_r;
  logic signed [EXT_W-1:0]  prod_ext;
  logic [SUM_W-1:0]         prod_term;
  logic [SUM_W-1:0]         acc_r;
  logic                     sum_ready_r;
  logic                     out_valid_r;
  logic [ROW_W-1:0]         out_row_r;
  logic [COL_W-1:0]         out_col_r;
  logic signed [SUM_W-1:0]  out_sum_r;
  logic                     out_last_r;

  // load side: indices past the store are dropped
  assign in_range = (int'(in_row) < MAX_N) && (int'(in_col) < MAX_N);
  assign wr_addr  = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(MAX_N)) + ADDR_W'(in_col);
  assign wr_elem  = ELEM_WIDTH'($signed(in_elem[LOAD_W-1:0]));

  // read addresses: A walks along the row, B down the column
  assign rd_k      = cmd.k[IDX_W-1:0];
  assign rd_j      = cmd.col[IDX_W-1:0];
  assign rd_addr_a = ADDR_W'(ADDR_W'(cmd.row) * ADDR_W'(MAX_N)) + ADDR_W'(rd_k);
  assign rd_addr_b = ADDR_W'(ADDR_W'(rd_k) * ADDR_W'(MAX_N)) + ADDR_W'(rd_j);

  smm_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_store_a (
    .clk   (clk),
    .we    (cmd.wr_a && in_range),
    .waddr (wr_addr),
    .wdata (wr_elem),
    .re    (cmd.rd_en),
    .raddr (rd_addr_a),
    .rdata (a_rd)
  );

  smm_ram #(
    .WIDTH (ELEM_WIDTH),
    .DEPTH (DEPTH)
  ) u_store_b (
    .clk   (clk),
    .we    (cmd.wr_b && in_range),
    .waddr (wr_addr),
    .wdata (wr_elem),
    .re    (cmd.rd_en),
    .raddr (rd_addr_b),
    .rdata (b_rd)
  );

  // product cut or sign-extended to the sum width
  assign prod_ext  = EXT_W'(prod_r);
  assign prod_term = prod_ext[SUM_W-1:0];

  // pipeline control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      sum_ready_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      v1_r        <= cmd.rd_en;
      v2_r        <= v1_r;
      sum_ready_r <= v2_r && last2_r;
      out_valid_r <= cmd.load_out || (out_valid_r && !out_ready);
    end
  end

  // multiply, accumulate and result register
  always_ff @(posedge clk) begin
    first1_r <= cmd.rd_first;
    last1_r  <= cmd.rd_last;
    first2_r <= first1_r;
    last2_r  <= last1_r;
    prod_r   <= $signed(a_rd) * $signed(b_rd);
    if (v2_r) begin
      acc_r <= first2_r ? prod_term : acc_r + prod_term;
    end
    if (cmd.load_out) begin
      out_row_r  <= cmd.row;
      out_col_r  <= COL_W'(rd_j);
      out_sum_r  <= $signed(acc_r);
      out_last_r <= cmd.out_last;
    end
  end

  assign status.sum_ready = sum_ready_r;
  assign status.out_busy  = out_valid_r && !out_ready;

  assign out_valid = out_valid_r;
  assign out_row   = out_row_r;
  assign out_col   = out_col_r;
  assign out_sum   = out_sum_r;
  assign out_last  = out_last_r;

endmodule

`default_nettype wire

// ===== rtl/square_matrix_multiply_unit.sv =====
// ----------------------------------------------------------------------------
// square_matrix_multiply_unit
// signed square matrix multiplier with one shared multiply-accumulate unit
//
//   port group  dir  handshake      beat contents
//   in_chan     in   valid/ready    mode, row_index, col_index, elem_value
//   out_chan    out  valid/ready    out_row, out_col, dot_sum, last_in_row
//   cfg_*       in   cfg_we         cfg_data = size_n
//
// a load beat is written as it is accepted, and the unit stays ready for the
// next one. during a compute beat for row i, each of the n result columns issues
// n store reads to the one multiply-accumulate unit, then waits for the read,
// multiply and add stages. reset is synchronous and leaves the stores as
// they were. the result register lets the next beat in while the final
// result of a row still waits; a stalled result holds the column sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module square_matrix_multiply_unit import smm_pkg::*; #(
  parameter int MAX_N      = 16,
  parameter int ELEM_WIDTH = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_data,
  smm_in_if.sink           in_chan,
  smm_out_if.source        out_chan
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  // sequencer
  smm_ctrl #(
    .MAX_N (MAX_N)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data),
    .in_valid (in_chan.valid),
    .in_ready (in_ready),
    .in_mode  (in_chan.mode),
    .in_row   (in_chan.row_index),
    .status   (status),
    .cmd      (cmd)
  );

  // stores and arithmetic
  smm_datapath #(
    .MAX_N      (MAX_N),
    .ELEM_WIDTH (ELEM_WIDTH)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .status    (status),
    .in_row    (in_chan.row_index),
    .in_col    (in_chan.col_index),
    .in_elem   (in_chan.elem_value),
    .out_ready (out_chan.ready),
    .out_valid (out_chan.valid),
    .out_row   (out_chan.out_row),
    .out_col   (out_chan.out_col),
    .out_sum   (out_chan.dot_sum),
    .out_last  (out_chan.last_in_row)
  );

  assign in_chan.ready = in_ready;

endmodule

`default_nettype wire

// ===== rtl/smm_checker.sv =====
// ----------------------------------------------------------------------------
// smm_checker
// port level checks of the matrix multiply unit, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

`include "square_matrix_multiply_unit_assert.svh"

module smm_checker import smm_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [MODE_W-1:0] in_mode,
  input logic              out_valid,
  input logic              out_ready,
  input logic [ROW_W-1:0]  out_row,
  input logic [COL_W-1:0]  out_col,
  input logic [SUM_W-1:0]  out_sum,
  input logic              out_last
);

  // no result beat straight after reset
  `SMM_ASSERT_NEXT(a_reset_quiet, !rst_n, !out_valid)

  // a stalled result beat holds
  `SMM_ASSERT_NEXT(a_out_hold, rst_n && out_valid && !out_ready, out_valid && $stable(out_sum) && $stable(out_col) && $stable(out_row) && $stable(out_last))

  // while a row is part way out the sequencer takes no new beat
  `SMM_ASSERT_NOW(a_row_busy, rst_n && out_valid && !out_last, !in_ready)

  // after a load beat the sequencer is ready again in the next cycle
  `SMM_ASSERT_NEXT(a_load_single, rst_n && in_valid && in_ready && (in_mode == MODE_WR_A || in_mode == MODE_WR_B), in_ready)

endmodule

bind square_matrix_multiply_unit smm_checker u_smm_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .in_mode   (in_chan.mode),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .out_row   (out_chan.out_row),
  .out_col   (out_chan.out_col),
  .out_sum   (out_chan.dot_sum),
  .out_last  (out_chan.last_in_row)
);

`default_nettype wire
